// ===== rtl/tpf_pkg.sv =====
// Shared constants and types for the tunnel-or-TCP frame filter.
// Used by tunnel_or_tcp_packet_filter; depends on nothing else.
package tpf_pkg;

    // Allow bitmap depth and the address width that follows from it.
    localparam int unsigned IFACE_SLOTS = 1024;
    localparam int unsigned IFACE_AW    = (IFACE_SLOTS > 1) ? $clog2(IFACE_SLOTS) : 1;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_IPV6      = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_FRAG    = 8'd44;
    localparam logic [15:0] PORT_VXLAN_A  = 16'd8472;
    localparam logic [15:0] PORT_VXLAN_B  = 16'd4789;
    localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
    localparam logic [7:0]  IHL_MASK      = 8'h0F;

    // Byte positions within the frame, counted from the destination address.
    localparam logic [6:0] POS_ETH_HI    = 7'd12;
    localparam logic [6:0] POS_ETH_LO    = 7'd13;
    localparam logic [6:0] POS_L3        = 7'd14;
    localparam logic [6:0] POS_V4_FRAG_H = 7'd20;
    localparam logic [6:0] POS_V4_FRAG_L = 7'd21;
    localparam logic [6:0] POS_V4_PROTO  = 7'd23;
    localparam logic [6:0] POS_V6_NEXT   = 7'd20;
    localparam logic [6:0] POS_V6_L4     = 7'd54;
    localparam logic [6:0] POS_V6_FRAG_L4 = 7'd62;
    localparam logic [6:0] POS_MAX       = 7'd127;

    typedef enum logic [2:0] {
        RSN_IFACE     = 3'd0,
        RSN_NOT_IP    = 3'd1,
        RSN_TCP       = 3'd2,
        RSN_VXLAN     = 3'd3,
        RSN_OTHER     = 3'd4,
        RSN_FRAGMENT  = 3'd5,
        RSN_TRUNCATED = 3'd6
    } t_reason;

    // Which captured fields are complete in the current frame.
    typedef struct packed {
        logic eth;
        logic proto;
        logic ihl;
        logic inner;
        logic src;
        logic dst;
    } t_seen;

endpackage

// ===== rtl/tunnel_or_tcp_packet_filter.sv =====
// Top level of the tunnel-or-TCP frame filter: byte parser, allow bitmap, verdict.
// Depends on tpf_pkg for constants, the reason codes and the field flags.
//
//  channel  | dir | fields (lowest bit first)                         | accepted when
//  s (in)   | in  | tuser: mode; tdata: iface, enable, data_byte; tlast | tvalid & tready
//  m (out)  | out | tdata: keep, reason                                | tvalid & tready
//
// One item is accepted per cycle while o_s_tready is high; a result leaves the output
// register after its last byte passes the input register and the bitmap read stage.
// After reset the bitmap is swept to zero, one entry a cycle, over all IFACE_SLOTS entries
// (1024); input tready stays low during that sweep.
// Each stage moves on whenever the stage after it is empty or emptying, so items
// keep entering while a result waits downstream.
module tunnel_or_tcp_packet_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] iface, [16] enable, [24:17] data_byte, zero pad
    input  logic        i_s_tuser,  // [0] mode
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata   // [0] keep, [3:1] reason, zero pad
);

    localparam int unsigned AW = tpf_pkg::IFACE_AW;

    // Bitmap clearing sweep.
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // Input stage.
    logic        r_av;
    logic        r_a_mode;
    logic [15:0] r_a_iface;
    logic        r_a_enable;
    logic [7:0]  r_a_byte;
    logic        r_a_last;

    // Frame parse state.
    logic [6:0]      r_pos, n_pos;
    logic [15:0]     r_frame_iface, n_frame_iface;
    logic [15:0]     r_ether_type, n_ether_type;
    logic [7:0]      r_ip_proto, n_ip_proto;
    logic [15:0]     r_frag, n_frag;
    logic [3:0]      r_hdr_words, n_hdr_words;
    logic [7:0]      r_inner_next, n_inner_next;
    logic [15:0]     r_src_port, n_src_port;
    logic [15:0]     r_dst_port, n_dst_port;
    tpf_pkg::t_seen  r_seen, n_seen;
    tpf_pkg::t_reason a_rsn;

    // Bitmap read stage.
    logic             r_bv;
    tpf_pkg::t_reason r_b_rsn;
    logic             r_b_inrange;
    logic             r_b_allow;

    // Output stage.
    logic             r_ov;
    logic             r_o_keep;
    tpf_pkg::t_reason r_o_rsn;

    logic r_allow_mem [tpf_pkg::IFACE_SLOTS];

    logic          adv_out, adv_b, a_res, a_fire, s_accept;
    logic          a_inrange, f_inrange;
    logic          mem_we, mem_wd, mem_re;
    logic [AW-1:0] mem_wa;
    tpf_pkg::t_reason b_final;

    assign adv_out  = !r_ov || i_m_tready;
    assign adv_b    = !r_bv || adv_out;
    assign a_res    = r_av && r_a_mode && r_a_last;
    assign a_fire   = r_av && (!a_res || adv_b);
    assign o_s_tready = !r_clearing && (!r_av || a_fire);
    assign s_accept = i_s_tvalid && o_s_tready;

    assign a_inrange = {1'b0, r_a_iface} < 17'(tpf_pkg::IFACE_SLOTS);
    assign f_inrange = {1'b0, n_frame_iface} < 17'(tpf_pkg::IFACE_SLOTS);

    assign mem_we = r_clearing || (a_fire && !r_a_mode && a_inrange);
    assign mem_wa = r_clearing ? r_clr_idx : r_a_iface[AW-1:0];
    assign mem_wd = r_clearing ? 1'b0 : r_a_enable;
    assign mem_re = a_fire && a_res;

    // Parser and interface-independent part of the verdict.
    always_comb begin
        logic [6:0] p;
        logic [6:0] l4;
        logic       do_grab;
        logic [7:0] b;
        logic [7:0] nh;
        logic       port_hit;
        tpf_pkg::t_reason udp_rsn;

        p  = r_pos;
        b  = r_a_byte;
        l4 = tpf_pkg::POS_V6_L4;
        do_grab = 1'b0;
        nh = 8'd0;

        n_pos         = r_pos;
        n_frame_iface = r_frame_iface;
        n_ether_type  = r_ether_type;
        n_ip_proto    = r_ip_proto;
        n_frag        = r_frag;
        n_hdr_words   = r_hdr_words;
        n_inner_next  = r_inner_next;
        n_src_port    = r_src_port;
        n_dst_port    = r_dst_port;
        n_seen        = r_seen;

        if (p == 7'd0) n_frame_iface = r_a_iface;
        if (p == tpf_pkg::POS_ETH_HI) n_ether_type[15:8] = b;
        if (p == tpf_pkg::POS_ETH_LO) begin
            n_ether_type[7:0] = b;
            n_seen.eth = 1'b1;
        end

        if (n_seen.eth && n_ether_type == tpf_pkg::ETH_IPV4) begin
            if (p == tpf_pkg::POS_L3) begin
                n_hdr_words = b[3:0] & tpf_pkg::IHL_MASK[3:0];
                n_seen.ihl  = 1'b1;
            end
            if (p == tpf_pkg::POS_V4_FRAG_H) n_frag[15:8] = b;
            if (p == tpf_pkg::POS_V4_FRAG_L) n_frag[7:0] = b;
            if (p == tpf_pkg::POS_V4_PROTO) begin
                n_ip_proto = b;
                n_seen.proto = 1'b1;
            end
            // L4 starts after the variable-length IPv4 header.
            l4 = tpf_pkg::POS_L3 + {1'b0, n_hdr_words, 2'b00};
            do_grab = n_seen.ihl;
        end else if (n_seen.eth && n_ether_type == tpf_pkg::ETH_IPV6) begin
            if (p == tpf_pkg::POS_V6_NEXT) begin
                n_ip_proto = b;
                n_seen.proto = 1'b1;
            end
            if (p == tpf_pkg::POS_V6_L4) begin
                n_inner_next = b;
                n_seen.inner = 1'b1;
            end
            l4 = (n_ip_proto == tpf_pkg::PROTO_FRAG) ? tpf_pkg::POS_V6_FRAG_L4
                                                     : tpf_pkg::POS_V6_L4;
            do_grab = n_seen.proto;
        end

        if (do_grab) begin
            if (p == l4) n_src_port[15:8] = b;
            if (p == 7'(l4 + 7'd1)) begin
                n_src_port[7:0] = b;
                n_seen.src = 1'b1;
            end
            if (p == 7'(l4 + 7'd2)) n_dst_port[15:8] = b;
            if (p == 7'(l4 + 7'd3)) begin
                n_dst_port[7:0] = b;
                n_seen.dst = 1'b1;
            end
        end

        if (r_pos != tpf_pkg::POS_MAX) n_pos = 7'(r_pos + 7'd1);

        port_hit = n_src_port == tpf_pkg::PORT_VXLAN_A || n_src_port == tpf_pkg::PORT_VXLAN_B
                || n_dst_port == tpf_pkg::PORT_VXLAN_A || n_dst_port == tpf_pkg::PORT_VXLAN_B;
        if (!(n_seen.src && n_seen.dst)) udp_rsn = tpf_pkg::RSN_TRUNCATED;
        else if (port_hit)               udp_rsn = tpf_pkg::RSN_VXLAN;
        else                             udp_rsn = tpf_pkg::RSN_OTHER;

        if (!n_seen.eth) begin
            a_rsn = tpf_pkg::RSN_TRUNCATED;
        end else if (n_ether_type == tpf_pkg::ETH_IPV4) begin
            if (!n_seen.proto)                              a_rsn = tpf_pkg::RSN_TRUNCATED;
            else if (n_ip_proto == tpf_pkg::PROTO_TCP)      a_rsn = tpf_pkg::RSN_TCP;
            else if (n_ip_proto != tpf_pkg::PROTO_UDP)      a_rsn = tpf_pkg::RSN_OTHER;
            else if ((n_frag & tpf_pkg::FRAG_OFS_MASK) != 16'd0) a_rsn = tpf_pkg::RSN_FRAGMENT;
            else                                            a_rsn = udp_rsn;
        end else if (n_ether_type == tpf_pkg::ETH_IPV6) begin
            nh = n_ip_proto;
            if (!n_seen.proto) begin
                a_rsn = tpf_pkg::RSN_TRUNCATED;
            end else if (nh == tpf_pkg::PROTO_TCP) begin
                a_rsn = tpf_pkg::RSN_TCP;
            end else if (nh == tpf_pkg::PROTO_FRAG && !n_seen.inner) begin
                a_rsn = tpf_pkg::RSN_TRUNCATED;
            end else begin
                // Look through one fragment header.
                if (nh == tpf_pkg::PROTO_FRAG) nh = n_inner_next;
                if (nh == tpf_pkg::PROTO_TCP)      a_rsn = tpf_pkg::RSN_TCP;
                else if (nh != tpf_pkg::PROTO_UDP) a_rsn = tpf_pkg::RSN_OTHER;
                else                               a_rsn = udp_rsn;
            end
        end else begin
            a_rsn = tpf_pkg::RSN_NOT_IP;
        end

        if (r_a_last) begin
            n_pos  = 7'd0;
            n_seen = '0;
        end
    end

    assign b_final = (!r_b_inrange || !r_b_allow) ? tpf_pkg::RSN_IFACE : r_b_rsn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_av       <= 1'b0;
            r_bv       <= 1'b0;
            r_ov       <= 1'b0;
            r_pos      <= '0;
            r_seen     <= '0;
        end else begin
            if (r_clearing) begin
                if (r_clr_idx == AW'(tpf_pkg::IFACE_SLOTS - 1)) r_clearing <= 1'b0;
                else                                             r_clr_idx <= AW'(r_clr_idx + 1'b1);
            end

            if (s_accept)    r_av <= 1'b1;
            else if (a_fire) r_av <= 1'b0;

            if (a_fire && r_a_mode) begin
                r_pos  <= n_pos;
                r_seen <= n_seen;
            end

            if (a_fire && a_res) r_bv <= 1'b1;
            else if (adv_out)    r_bv <= 1'b0;

            if (r_bv && adv_out)  r_ov <= 1'b1;
            else if (i_m_tready)  r_ov <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_mode   <= i_s_tuser;
            r_a_iface  <= i_s_tdata[15:0];
            r_a_enable <= i_s_tdata[16];
            r_a_byte   <= i_s_tdata[24:17];
            r_a_last   <= i_s_tlast;
        end
        if (a_fire && r_a_mode) begin
            r_frame_iface <= n_frame_iface;
            r_ether_type  <= n_ether_type;
            r_ip_proto    <= n_ip_proto;
            r_frag        <= n_frag;
            r_hdr_words   <= n_hdr_words;
            r_inner_next  <= n_inner_next;
            r_src_port    <= n_src_port;
            r_dst_port    <= n_dst_port;
        end
        if (a_fire && a_res) begin
            r_b_rsn     <= a_rsn;
            r_b_inrange <= f_inrange;
        end
        if (r_bv && adv_out) begin
            r_o_rsn  <= b_final;
            r_o_keep <= (b_final == tpf_pkg::RSN_TCP) || (b_final == tpf_pkg::RSN_VXLAN);
        end
    end

    // Allow bitmap: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_allow_mem[mem_wa] <= mem_wd;
        if (mem_re) r_b_allow <= r_allow_mem[n_frame_iface[AW-1:0]];
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0000, r_o_rsn, r_o_keep};

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_s_tready)
        else $error("input accepted during bitmap clear");

    a_keep_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_keep == ((r_o_rsn == tpf_pkg::RSN_TCP) || (r_o_rsn == tpf_pkg::RSN_VXLAN))))
        else $error("keep flag disagrees with reason");

    a_frame_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == 7'd0) |-> (r_seen == '0))
        else $error("field flags set at frame start");

    a_b_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bv && !adv_out) |=> r_bv)
        else $error("verdict lost while output stalled");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bv && adv_out) |=> r_ov)
        else $error("verdict did not reach output register");

endmodule

// ===== test/tunnel_or_tcp_packet_filter_tb.sv =====
// Self-checking testbench for tunnel_or_tcp_packet_filter: drives allow-table writes and
// Ethernet frames byte by byte, predicts each frame verdict and checks it on the output.
// Depends on tpf_pkg and the filter RTL only.
module tunnel_or_tcp_packet_filter_tb;

    localparam bit MODE_TABLE = 1'b0;
    localparam bit MODE_FRAME = 1'b1;
    localparam int MAX_FRAME  = 140;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        FK_V4_TCP, FK_V4_UDP_TUN, FK_V4_UDP_PLAIN, FK_V4_FRAG, FK_V4_OTHER,
        FK_V6_TCP, FK_V6_UDP, FK_V6_FRAG_TCP, FK_V6_FRAG_UDP, FK_V6_FRAG_OTHER,
        FK_V6_OTHER, FK_NOT_IP, FK_NOISE
    } t_frame_kind;

    // Tracks the parser state of the filter and holds the verdicts still owed by it.
    class t_filter_scoreboard;
        bit        allow_tab [tpf_pkg::IFACE_SLOTS];
        bit [6:0]  pos;
        bit [15:0] fr_iface, eth_type, frag_word, sport, dport;
        bit [7:0]  proto, inner_nh;
        bit [3:0]  ihl;
        bit        got_eth, got_proto, got_ihl, got_inner, got_src, got_dst;
        tpf_pkg::t_reason verdicts[$];
        int        errors;

        function int pending();
            return verdicts.size();
        endfunction

        function void take_port_byte(int p, int l4, bit [7:0] b);
            if (p == l4) sport = {b, 8'h00};
            if (p == l4 + 1) begin
                sport[7:0] = b;
                got_src = 1'b1;
            end
            if (p == l4 + 2) dport = {b, 8'h00};
            if (p == l4 + 3) begin
                dport[7:0] = b;
                got_dst = 1'b1;
            end
        endfunction

        function tpf_pkg::t_reason port_verdict();
            if (!(got_src && got_dst)) return tpf_pkg::RSN_TRUNCATED;
            if (sport == tpf_pkg::PORT_VXLAN_A || sport == tpf_pkg::PORT_VXLAN_B ||
                dport == tpf_pkg::PORT_VXLAN_A || dport == tpf_pkg::PORT_VXLAN_B)
                return tpf_pkg::RSN_VXLAN;
            return tpf_pkg::RSN_OTHER;
        endfunction

        function tpf_pkg::t_reason verdict();
            bit [7:0] nh;
            if (fr_iface >= tpf_pkg::IFACE_SLOTS ||
                !allow_tab[fr_iface[tpf_pkg::IFACE_AW-1:0]]) return tpf_pkg::RSN_IFACE;
            if (!got_eth) return tpf_pkg::RSN_TRUNCATED;
            if (eth_type == tpf_pkg::ETH_IPV4) begin
                if (!got_proto) return tpf_pkg::RSN_TRUNCATED;
                if (proto == tpf_pkg::PROTO_TCP) return tpf_pkg::RSN_TCP;
                if (proto != tpf_pkg::PROTO_UDP) return tpf_pkg::RSN_OTHER;
                if ((frag_word & tpf_pkg::FRAG_OFS_MASK) != 16'd0) return tpf_pkg::RSN_FRAGMENT;
                return port_verdict();
            end
            if (eth_type == tpf_pkg::ETH_IPV6) begin
                if (!got_proto) return tpf_pkg::RSN_TRUNCATED;
                nh = proto;
                if (nh == tpf_pkg::PROTO_TCP) return tpf_pkg::RSN_TCP;
                if (nh == tpf_pkg::PROTO_FRAG) begin
                    if (!got_inner) return tpf_pkg::RSN_TRUNCATED;
                    nh = inner_nh;
                    if (nh == tpf_pkg::PROTO_TCP) return tpf_pkg::RSN_TCP;
                end
                if (nh != tpf_pkg::PROTO_UDP) return tpf_pkg::RSN_OTHER;
                return port_verdict();
            end
            return tpf_pkg::RSN_NOT_IP;
        endfunction

        function void note_input(bit mode, bit [15:0] iface, bit en, bit [7:0] b, bit is_last);
            int p;
            if (mode == MODE_TABLE) begin
                if (iface < tpf_pkg::IFACE_SLOTS) allow_tab[iface[tpf_pkg::IFACE_AW-1:0]] = en;
                return;
            end
            p = pos;
            if (p == 0) fr_iface = iface;
            if (p == 12) eth_type = {b, 8'h00};
            if (p == 13) begin
                eth_type[7:0] = b;
                got_eth = 1'b1;
            end
            if (got_eth && eth_type == tpf_pkg::ETH_IPV4) begin
                if (p == 14) begin
                    ihl = b[3:0];
                    got_ihl = 1'b1;
                end
                if (p == 20) frag_word = {b, 8'h00};
                if (p == 21) frag_word[7:0] = b;
                if (p == 23) begin
                    proto = b;
                    got_proto = 1'b1;
                end
                // A short IHL may put the port bytes on top of header bytes.
                if (got_ihl) take_port_byte(p, 14 + 4 * int'(ihl), b);
            end else if (got_eth && eth_type == tpf_pkg::ETH_IPV6) begin
                if (p == 20) begin
                    proto = b;
                    got_proto = 1'b1;
                end
                if (p == 54) begin
                    inner_nh = b;
                    got_inner = 1'b1;
                end
                if (got_proto) take_port_byte(p, (proto == tpf_pkg::PROTO_FRAG) ? 62 : 54, b);
            end
            if (pos < tpf_pkg::POS_MAX) pos++;
            if (is_last) begin
                verdicts.push_back(verdict());
                pos = '0;
                {got_eth, got_proto, got_ihl, got_inner, got_src, got_dst} = '0;
            end
        endfunction

        function void check_result(bit [7:0] tdata);
            tpf_pkg::t_reason want;
            bit      want_keep;
            if (verdicts.size() == 0) begin
                $display("%0t: verdict with none expected, actual keep=%0b reason=%0d",
                         $time, tdata[0], tdata[3:1]);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            want_keep = (want == tpf_pkg::RSN_TCP || want == tpf_pkg::RSN_VXLAN);
            if (tdata[0] !== want_keep) begin
                $display("%0t: keep mismatch, expected %0b, actual %0b",
                         $time, want_keep, tdata[0]);
                errors++;
            end
            if (tdata[3:1] !== want) begin
                $display("%0t: reason mismatch, expected %0d, actual %0d",
                         $time, want, tdata[3:1]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_tready;
    logic [31:0] s_tdata;   // [15:0] iface, [16] enable, [24:17] data_byte, zero pad
    logic        s_tuser;   // [0] mode
    logic        s_tlast;
    logic        o_m_tvalid;
    logic        m_tready;
    logic [7:0]  o_m_tdata; // [0] keep, [3:1] reason, zero pad

    t_filter_scoreboard sb = new();
    bit [7:0] frame_bytes[$];
    bit       src_busy;
    bit       sink_busy;
    bit       hold_req;
    int       items_sent;

    tunnel_or_tcp_packet_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap(bit busy);
        int r;
        if (!busy) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit [15:0] pick_iface();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 16'($urandom_range(0, 7));
        if (r < 80) return 16'($urandom_range(8, 15));
        if (r < 88) return 16'(tpf_pkg::IFACE_SLOTS - 1);
        if (r < 92) return 16'(tpf_pkg::IFACE_SLOTS + $urandom_range(0, 3));
        return 16'($urandom);
    endfunction

    task automatic send_item(input bit mode, input bit [15:0] iface, input bit en,
                             input bit [7:0] b, input bit is_last);
        int gap;
        gap = pick_gap(src_busy);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, b, en, iface};
        s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(mode, iface, en, b, is_last);
        items_sent++;
    endtask

    task automatic write_allow(input bit [15:0] iface, input bit en);
        send_item(MODE_TABLE, iface, en, 8'($urandom), 1'($urandom));
    endtask

    // len_req: -1 picks a random length (some truncated, some long), 0 a complete
    // frame, anything above 0 that exact length, capped at MAX_FRAME.
    task automatic build_frame(input t_frame_kind kind, input int ihl_req, input int len_req);
        bit [7:0]  raw [MAX_FRAME];
        bit [15:0] sp, dp;
        int        i, ihl, l4, need, len, r;
        for (i = 0; i < MAX_FRAME; i++) raw[i] = 8'($urandom);
        sp = 16'($urandom);
        dp = 16'($urandom);
        if (kind == FK_V4_UDP_TUN ||
            (kind inside {FK_V4_FRAG, FK_V6_UDP, FK_V6_FRAG_UDP} && $urandom_range(0, 1))) begin
            case ($urandom_range(0, 3))
                0: sp = tpf_pkg::PORT_VXLAN_A;
                1: sp = tpf_pkg::PORT_VXLAN_B;
                2: dp = tpf_pkg::PORT_VXLAN_A;
                default: dp = tpf_pkg::PORT_VXLAN_B;
            endcase
        end
        ihl = (ihl_req >= 0) ? ihl_req :
              (($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 5);
        need = 14;
        if (kind inside {FK_V4_TCP, FK_V4_UDP_TUN, FK_V4_UDP_PLAIN, FK_V4_FRAG, FK_V4_OTHER})
        begin
            l4 = 14 + 4 * ihl;
            {raw[l4], raw[l4 + 1], raw[l4 + 2], raw[l4 + 3]} = {sp, dp};
            raw[12] = tpf_pkg::ETH_IPV4[15:8];
            raw[13] = tpf_pkg::ETH_IPV4[7:0];
            raw[14] = 8'h40 | 8'(ihl);
            raw[20] = raw[20] & 8'hE0;
            raw[21] = 8'h00;
            case (kind)
                FK_V4_TCP: raw[23] = tpf_pkg::PROTO_TCP;
                FK_V4_OTHER: raw[23] = 8'($urandom);
                FK_V4_FRAG: begin
                    raw[23] = tpf_pkg::PROTO_UDP;
                    raw[21] = 8'($urandom_range(1, 255));
                    raw[20] = 8'($urandom);
                end
                default: raw[23] = tpf_pkg::PROTO_UDP;
            endcase
            need = (l4 + 4 > 24) ? l4 + 4 : 24;
        end else if (kind != FK_NOT_IP && kind != FK_NOISE) begin
            raw[12] = tpf_pkg::ETH_IPV6[15:8];
            raw[13] = tpf_pkg::ETH_IPV6[7:0];
            need = 21;
            case (kind)
                FK_V6_TCP: raw[20] = tpf_pkg::PROTO_TCP;
                FK_V6_OTHER: raw[20] = 8'($urandom);
                FK_V6_UDP: begin
                    raw[20] = tpf_pkg::PROTO_UDP;
                    {raw[54], raw[55], raw[56], raw[57]} = {sp, dp};
                    need = 58;
                end
                FK_V6_FRAG_UDP: begin
                    raw[20] = tpf_pkg::PROTO_FRAG;
                    raw[54] = tpf_pkg::PROTO_UDP;
                    {raw[62], raw[63], raw[64], raw[65]} = {sp, dp};
                    need = 66;
                end
                default: begin
                    raw[20] = tpf_pkg::PROTO_FRAG;
                    raw[54] = (kind == FK_V6_FRAG_TCP) ? tpf_pkg::PROTO_TCP : 8'($urandom);
                    need = 55;
                end
            endcase
        end else if (kind == FK_NOT_IP) begin
            // Near misses of the two IP ethertypes now and then.
            r = $urandom_range(0, 3);
            if (r == 0)
                {raw[12], raw[13]} = tpf_pkg::ETH_IPV4 ^ (16'd1 << $urandom_range(0, 15));
            if (r == 1)
                {raw[12], raw[13]} = tpf_pkg::ETH_IPV6 ^ (16'd1 << $urandom_range(0, 15));
        end else begin
            need = $urandom_range(1, 80);
        end
        if (len_req > 0) begin
            len = len_req;
        end else if (len_req == 0) begin
            len = need + $urandom_range(0, 10);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 12) len = $urandom_range(1, need);
            else if (r < 15) len = $urandom_range(128, MAX_FRAME);
            else len = need + $urandom_range(0, 10);
        end
        if (len > MAX_FRAME) len = MAX_FRAME;
        frame_bytes.delete();
        for (i = 0; i < len; i++) frame_bytes.push_back(raw[i]);
    endtask

    // Table writes occasionally land in the middle of a frame; iface on later bytes
    // is ignored by the block, so it is left random there.
    task automatic send_frame(input bit [15:0] iface);
        int i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            if (i > 0 && $urandom_range(0, 49) == 0)
                write_allow(16'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
            send_item(MODE_FRAME, (i == 0) ? iface : 16'($urandom), 1'($urandom),
                      frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic run_frame(input t_frame_kind kind, input bit [15:0] iface,
                             input int ihl_req, input int len_req);
        build_frame(kind, ihl_req, len_req);
        send_frame(iface);
    endtask

    // Output side: random stalls, plus one long hold-off when asked for.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && m_tready) sb.check_result(o_m_tdata);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(sink_busy);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        int n_frames;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= MODE_TABLE;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        src_busy  = 1'b1;
        sink_busy = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table edges, then a few frames that hit the corners.
        write_allow(0, 1'b1);
        write_allow(1, 1'b1);
        write_allow(2, 1'b1);
        write_allow(3, 1'b1);
        write_allow(16'(tpf_pkg::IFACE_SLOTS - 1), 1'b1);
        write_allow(16'(tpf_pkg::IFACE_SLOTS), 1'b1);
        write_allow(16'hFFFF, 1'b1);
        write_allow(5, 1'b1);
        write_allow(5, 1'b0);
        run_frame(FK_NOISE, 0, -1, 1);
        run_frame(FK_V4_TCP, 0, 0, 0);
        run_frame(FK_V4_UDP_TUN, 1, 2, 0);
        run_frame(FK_V4_FRAG, 3, 5, 0);
        run_frame(FK_V6_FRAG_UDP, 3, -1, 0);
        // The interface is checked first, so a single byte per frame is enough here.
        run_frame(FK_V4_TCP, 16'(tpf_pkg::IFACE_SLOTS), 5, 1);
        run_frame(FK_V4_TCP, 16'hFFFF, 5, 1);
        run_frame(FK_V4_TCP, 5, 5, 1);
        run_frame(FK_V4_TCP, 16'(tpf_pkg::IFACE_SLOTS - 1), 5, 1);
        run_frame(FK_V4_UDP_TUN, 0, 5, MAX_FRAME);
        run_frame(FK_V4_UDP_TUN, 1, 5, 20);

        // Hold the output off while tiny frames keep coming, so the block backs up.
        src_busy = 1'b0;
        hold_req = 1'b1;
        repeat (30) run_frame(FK_NOISE, pick_iface(), -1, $urandom_range(1, 2));

        n_frames = 0;
        while (items_sent < 400) begin
            if (n_frames % 6 == 0) begin
                src_busy  = $urandom_range(0, 3) != 0;
                sink_busy = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 9) == 0)
                write_allow(16'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 49) == 0)
                write_allow(16'($urandom), 1'($urandom));
            run_frame(t_frame_kind'($urandom_range(0, FK_NOISE)), pick_iface(), -1, -1);
            n_frames++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
